FILE: hdl/ctuc_pkg.sv
// ctuc_pkg: shared constants, register index codes and status codes for the
// camera tick to utc converter; used by the top level and its checker
package ctuc_pkg;

   // fraction steps of the exact multiply-divide
   localparam int FRACTION_BITS = 32;
   localparam int DIV_STAGES    = 64;
   localparam int SCALE_STAGES  = 2 * FRACTION_BITS;
   // accept edge to strobe cycle
   localparam int LATENCY       = DIV_STAGES + SCALE_STAGES + 3;

   localparam logic [63:0] NS_PER_SEC   = 64'd1_000_000_000;
   localparam logic [29:0] NS_PER_SEC30 = 30'd1_000_000_000;
   localparam logic [63:0] SMAX64       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SECS_MAX     = SMAX64 / NS_PER_SEC;

   localparam logic [5:0]  QUALITY_RESET     = 6'd44;
   localparam logic [63:0] UNCERTAINTY_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      REG_MODEL_MODE      = 4'd0,
      REG_ANCHOR_TICKS    = 4'd1,
      REG_ANCHOR_RATE     = 4'd2,
      REG_ANCHOR_UTC      = 4'd3,
      REG_VALID_FROM      = 4'd4,
      REG_REVISION        = 4'd5,
      REG_QUALITY         = 4'd6,
      REG_UNCERTAINTY     = 4'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CORRECTED     = 3'd0,
      ST_BAD_RAW       = 3'd1,
      ST_NO_MODEL      = 3'd2,
      ST_BAD_MODEL     = 3'd3,
      ST_MISSING       = 3'd4,
      ST_RATE_MISMATCH = 3'd5,
      ST_NOT_YET_VALID = 3'd6,
      ST_OVERFLOW      = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      MODE_NONE      = 2'd0,
      MODE_NO_ANCHOR = 2'd1,
      MODE_ANCHORED  = 2'd2,
      MODE_PARTIAL   = 2'd3
   } mode_type;

endpackage

FILE: hdl/camera_tick_to_utc_converter_top.sv
// camera_tick_to_utc_converter_top: checks a frame stamp against the clock
// model and converts ticks to utc ns; depends on ctuc_pkg
//
// Usage
//  - request: raise start with the req_ fields; a transfer happens at each
//    rising edge with start high and busy low. busy is high only in reset,
//    so a frame can be taken every cycle.
//  - result: rsp_valid strobes for one cycle with rsp_status,
//    rsp_corrected_utc_ns and rsp_arrival_wall_ns. Results leave in request
//    order, exactly one per request.
//  - pipeline: throughput one frame per cycle. The registers are the check
//    stage, the 64 one-bit stages of the seconds divider, the range check
//    stage, the 64 half-steps of the 32-bit shift-and-subtract fraction
//    scaler, the delta stage and the output stage.
//  - csr port: csr_write_enable with csr_index and csr_write_data writes one
//    model register; write only while no frame is in flight.
//  - reset: synchronous, clears the pipeline valid bits and loads the model
//    register defaults (no model, quality 44, uncertainty -1).
//  - the receiver cannot stall; a result is shown once and gone.
module camera_tick_to_utc_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_ticks_present,
   input  logic [63:0] req_frame_ticks,
   input  logic        req_rate_present,
   input  logic [63:0] req_frame_rate_hz,
   input  logic signed [63:0] req_received_mono_ns,
   input  logic signed [63:0] req_received_wall_ns,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic signed [63:0] rsp_corrected_utc_ns,
   output logic signed [63:0] rsp_arrival_wall_ns
);

   localparam int ND = ctuc_pkg::DIV_STAGES;
   localparam int NS = ctuc_pkg::SCALE_STAGES;
   localparam int FB = ctuc_pkg::FRACTION_BITS;

   // model registers
   logic [1:0]  mode_ff;
   logic [63:0] anchor_ticks_ff;
   logic [63:0] anchor_rate_ff;
   logic [63:0] anchor_utc_ff;
   logic [63:0] valid_from_ff;
   logic [31:0] revision_ff;
   logic [5:0]  quality_ff;
   logic [63:0] uncertainty_ff;

   assign busy = reset;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= ctuc_pkg::MODE_NONE;
         anchor_ticks_ff <= '0;
         anchor_rate_ff  <= '0;
         anchor_utc_ff   <= '0;
         valid_from_ff   <= '0;
         revision_ff     <= '0;
         quality_ff      <= ctuc_pkg::QUALITY_RESET;
         uncertainty_ff  <= ctuc_pkg::UNCERTAINTY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ctuc_pkg::REG_MODEL_MODE:   mode_ff         <= csr_write_data[1:0];
            ctuc_pkg::REG_ANCHOR_TICKS: anchor_ticks_ff <= csr_write_data;
            ctuc_pkg::REG_ANCHOR_RATE:  anchor_rate_ff  <= csr_write_data;
            ctuc_pkg::REG_ANCHOR_UTC:   anchor_utc_ff   <= csr_write_data;
            ctuc_pkg::REG_VALID_FROM:   valid_from_ff   <= csr_write_data;
            ctuc_pkg::REG_REVISION:     revision_ff     <= csr_write_data[31:0];
            ctuc_pkg::REG_QUALITY:      quality_ff      <= csr_write_data[5:0];
            ctuc_pkg::REG_UNCERTAINTY:  uncertainty_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // frame checks in priority order
   logic [2:0]  chk_status_in;
   logic        model_ok_in;
   logic [2:0]  src_in;
   logic [2:0]  sst_in;
   logic        neg_in;
   logic [63:0] mag_in;
   logic        accept_in;

   assign accept_in = start && !busy;

   always_comb begin
      src_in = quality_ff[5:3];
      sst_in = quality_ff[2:0];
      model_ok_in = 1'b1;
      if (revision_ff == '0) model_ok_in = 1'b0;
      if (src_in > 3'd4 || sst_in > 3'd2) model_ok_in = 1'b0;
      if (sst_in == 3'd0 && (src_in == 3'd3 || src_in == 3'd4)) model_ok_in = 1'b0;
      if (mode_ff == ctuc_pkg::MODE_PARTIAL) model_ok_in = 1'b0;
      if (mode_ff == ctuc_pkg::MODE_ANCHORED && anchor_rate_ff == '0) model_ok_in = 1'b0;
      if (uncertainty_ff[63]) model_ok_in = 1'b0;
      priority if ((req_ticks_present != req_rate_present)
                   || (req_rate_present && req_frame_rate_hz == '0))
         chk_status_in = ctuc_pkg::ST_BAD_RAW;
      else if (mode_ff == ctuc_pkg::MODE_NONE)
         chk_status_in = ctuc_pkg::ST_NO_MODEL;
      else if (!model_ok_in)
         chk_status_in = ctuc_pkg::ST_BAD_MODEL;
      else if (!req_ticks_present || mode_ff != ctuc_pkg::MODE_ANCHORED)
         chk_status_in = ctuc_pkg::ST_MISSING;
      else if (req_frame_rate_hz != anchor_rate_ff)
         chk_status_in = ctuc_pkg::ST_RATE_MISMATCH;
      else if ($signed(req_received_mono_ns) < $signed(valid_from_ff))
         chk_status_in = ctuc_pkg::ST_NOT_YET_VALID;
      else
         chk_status_in = ctuc_pkg::ST_CORRECTED;
      neg_in = req_frame_ticks < anchor_ticks_ff;
      mag_in = neg_in ? anchor_ticks_ff - req_frame_ticks
                      : req_frame_ticks - anchor_ticks_ff;
   end

   // divider pipeline: index 0 is the check stage, qd shifts dividend out
   // and quotient in
   logic        dv_valid_ff  [0:ND];
   logic [2:0]  dv_status_ff [0:ND];
   logic        dv_neg_ff    [0:ND];
   logic [63:0] dv_rate_ff   [0:ND];
   logic [63:0] dv_wall_ff   [0:ND];
   logic [63:0] dv_qd_ff     [0:ND];
   logic [63:0] dv_rem_ff    [0:ND];

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else       dv_valid_ff[0] <= accept_in;
      dv_status_ff[0] <= chk_status_in;
      dv_neg_ff[0]    <= neg_in;
      dv_rate_ff[0]   <= req_frame_rate_hz;
      dv_wall_ff[0]   <= req_received_wall_ns;
      dv_qd_ff[0]     <= mag_in;
      dv_rem_ff[0]    <= '0;
   end

   for (genvar i = 0; i < ND; i++) begin : g_div
      logic [64:0] trial_in;
      logic        ge_in;
      logic [64:0] diff_in;
      always_comb begin
         trial_in = {dv_rem_ff[i], dv_qd_ff[i][63]};
         ge_in    = trial_in >= {1'b0, dv_rate_ff[i]};
         diff_in  = trial_in - {1'b0, dv_rate_ff[i]};
      end
      // one quotient bit per stage
      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[i+1] <= 1'b0;
         else       dv_valid_ff[i+1] <= dv_valid_ff[i];
         dv_status_ff[i+1] <= dv_status_ff[i];
         dv_neg_ff[i+1]    <= dv_neg_ff[i];
         dv_rate_ff[i+1]   <= dv_rate_ff[i];
         dv_wall_ff[i+1]   <= dv_wall_ff[i];
         dv_qd_ff[i+1]     <= {dv_qd_ff[i][62:0], ge_in};
         dv_rem_ff[i+1]    <= ge_in ? diff_in[63:0] : trial_in[63:0];
      end
   end

   // seconds range check and whole-second product
   logic        sc_valid_ff  [0:NS];
   logic [2:0]  sc_status_ff [0:NS];
   logic        sc_neg_ff    [0:NS];
   logic [63:0] sc_div_ff    [0:NS];
   logic [63:0] sc_wall_ff   [0:NS];
   logic [63:0] sc_whole_ff  [0:NS];
   logic [63:0] sc_val_ff    [0:NS];
   logic [63:0] sc_r_ff      [0:NS];
   logic [FB-1:0] sc_q_ff    [0:NS];

   logic [2:0]  w_status_in;
   logic [63:0] w_whole_in;

   always_comb begin
      w_status_in = dv_status_ff[ND];
      if (w_status_in == ctuc_pkg::ST_CORRECTED && dv_qd_ff[ND] > ctuc_pkg::SECS_MAX)
         w_status_in = ctuc_pkg::ST_OVERFLOW;
      w_whole_in = {30'd0, dv_qd_ff[ND][33:0]} * {34'd0, ctuc_pkg::NS_PER_SEC30};
   end

   always_ff @(posedge clock) begin
      if (reset) sc_valid_ff[0] <= 1'b0;
      else       sc_valid_ff[0] <= dv_valid_ff[ND];
      sc_status_ff[0] <= w_status_in;
      sc_neg_ff[0]    <= dv_neg_ff[ND];
      sc_div_ff[0]    <= dv_rate_ff[ND];
      sc_wall_ff[0]   <= dv_wall_ff[ND];
      sc_whole_ff[0]  <= w_whole_in;
      sc_val_ff[0]    <= dv_rem_ff[ND];
      sc_r_ff[0]      <= '0;
      sc_q_ff[0]      <= '0;
   end

   // fraction scaler: even steps double, odd steps add where the ns bit is set
   for (genvar j = 0; j < NS; j++) begin : g_scale
      localparam int BIT = FB - 1 - j / 2;
      logic [64:0]   sum_in;
      logic          hit_in;
      logic [64:0]   sub_in;
      logic [63:0]   r_in;
      logic [FB-1:0] q_in;
      always_comb begin
         if (j % 2 == 0) begin
            sum_in = {sc_r_ff[j], 1'b0};
         end else begin
            sum_in = {1'b0, sc_r_ff[j]} + {1'b0, sc_val_ff[j]};
         end
         hit_in = sum_in >= {1'b0, sc_div_ff[j]};
         sub_in = sum_in - {1'b0, sc_div_ff[j]};
         if (j % 2 == 0) begin
            r_in = hit_in ? sub_in[63:0] : sum_in[63:0];
            q_in = {sc_q_ff[j][FB-2:0], hit_in};
         end else if (ctuc_pkg::NS_PER_SEC[BIT]) begin
            r_in = hit_in ? sub_in[63:0] : sum_in[63:0];
            q_in = sc_q_ff[j] + FB'(hit_in);
         end else begin
            r_in = sc_r_ff[j];
            q_in = sc_q_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) sc_valid_ff[j+1] <= 1'b0;
         else       sc_valid_ff[j+1] <= sc_valid_ff[j];
         sc_status_ff[j+1] <= sc_status_ff[j];
         sc_neg_ff[j+1]    <= sc_neg_ff[j];
         sc_div_ff[j+1]    <= sc_div_ff[j];
         sc_wall_ff[j+1]   <= sc_wall_ff[j];
         sc_whole_ff[j+1]  <= sc_whole_ff[j];
         sc_val_ff[j+1]    <= sc_val_ff[j];
         sc_r_ff[j+1]      <= r_in;
         sc_q_ff[j+1]      <= q_in;
      end
   end

   // delta stage: range check and sign
   logic        dl_valid_ff;
   logic [2:0]  dl_status_ff;
   logic [63:0] dl_delta_ff;
   logic [63:0] dl_wall_ff;
   logic [2:0]  dl_status_in;
   logic [63:0] dl_frac_in;
   logic [63:0] dl_delta_in;

   always_comb begin
      dl_frac_in   = 64'(sc_q_ff[NS]);
      dl_status_in = sc_status_ff[NS];
      if (dl_status_in == ctuc_pkg::ST_CORRECTED
          && dl_frac_in > ctuc_pkg::SMAX64 - sc_whole_ff[NS])
         dl_status_in = ctuc_pkg::ST_OVERFLOW;
      dl_delta_in = sc_whole_ff[NS] + dl_frac_in;
      if (sc_neg_ff[NS]) dl_delta_in = 64'd0 - dl_delta_in;
   end

   always_ff @(posedge clock) begin
      if (reset) dl_valid_ff <= 1'b0;
      else       dl_valid_ff <= sc_valid_ff[NS];
      dl_status_ff <= dl_status_in;
      dl_delta_ff  <= dl_delta_in;
      dl_wall_ff   <= sc_wall_ff[NS];
   end

   // output stage: anchor add and signed overflow
   logic        out_valid_ff;
   logic [2:0]  out_status_ff;
   logic [63:0] out_utc_ff;
   logic [63:0] out_wall_ff;
   logic [63:0] out_sum_in;
   logic [2:0]  out_status_in;

   always_comb begin
      out_sum_in    = anchor_utc_ff + dl_delta_ff;
      out_status_in = dl_status_ff;
      if (out_status_in == ctuc_pkg::ST_CORRECTED
          && anchor_utc_ff[63] == dl_delta_ff[63] && out_sum_in[63] != dl_delta_ff[63])
         out_status_in = ctuc_pkg::ST_OVERFLOW;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= dl_valid_ff;
      out_status_ff <= out_status_in;
      out_utc_ff    <= (out_status_in == ctuc_pkg::ST_CORRECTED) ? out_sum_in : '0;
      out_wall_ff   <= dl_wall_ff;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_corrected_utc_ns = out_utc_ff;
   assign rsp_arrival_wall_ns  = out_wall_ff;

endmodule

FILE: hdl/ctuc_checker.sv
// ctuc_checker: port-level checks of the converter's result timing and fields
// depends on ctuc_pkg; bound to camera_tick_to_utc_converter_top
module ctuc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [63:0] req_received_wall_ns,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [63:0] rsp_corrected_utc_ns,
   input logic [63:0] rsp_arrival_wall_ns
);

   // the assertions sample the strobe at the edge that ends its cycle
   localparam int RESULT_EDGE = ctuc_pkg::LATENCY + 1;

   // every transfer gives one strobe after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(RESULT_EDGE) rsp_valid)
      else $error("missing result");

   // no strobe without a matching request
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RESULT_EDGE))
      else $error("result without request");

   // corrected time is zero unless corrected
   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ctuc_pkg::ST_CORRECTED) |-> rsp_corrected_utc_ns == '0)
      else $error("nonzero time on failed status");

   // receive time travels with its frame
   a_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_arrival_wall_ns == $past(req_received_wall_ns, RESULT_EDGE))
      else $error("arrival time mismatch");

endmodule

bind camera_tick_to_utc_converter_top ctuc_checker u_ctuc_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_received_wall_ns (req_received_wall_ns),
   .rsp_valid            (rsp_valid),
   .rsp_status           (rsp_status),
   .rsp_corrected_utc_ns (rsp_corrected_utc_ns),
   .rsp_arrival_wall_ns  (rsp_arrival_wall_ns)
);

FILE: tb/camera_tick_to_utc_converter_top_tb.sv
// camera_tick_to_utc_converter_top_tb: self-checking bench for the tick to utc converter
// predicts each frame result from its own model copy; depends on ctuc_pkg and the top level
module camera_tick_to_utc_converter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4 * ctuc_pkg::LATENCY + 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_ticks_present = 1'b0;
   logic [63:0] req_frame_ticks = '0;
   logic        req_rate_present = 1'b0;
   logic [63:0] req_frame_rate_hz = '0;
   logic signed [63:0] req_received_mono_ns = '0;
   logic signed [63:0] req_received_wall_ns = '0;
   logic        csr_write_enable = 1'b0;
   logic [3:0]  csr_index = '0;
   logic [63:0] csr_write_data = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic signed [63:0] rsp_corrected_utc_ns;
   logic signed [63:0] rsp_arrival_wall_ns;

   typedef struct packed {
      ctuc_pkg::status_type status;
      logic [63:0] utc;
      logic [63:0] wall;
   } frame_result_type;

   frame_result_type pending_results[$];

   // model register copy
   ctuc_pkg::mode_type cfg_mode;
   logic [63:0] cfg_anchor_ticks, cfg_rate, cfg_anchor_utc, cfg_valid_from;
   logic [31:0] cfg_revision;
   logic [5:0]  cfg_quality;
   logic [63:0] cfg_uncertainty;

   int  mismatches = 0;
   int  stall_cycles = 0;
   bit  idle_on = 1'b1;

   camera_tick_to_utc_converter_top dut (.*);

   always #1 clock = ~clock;

   // exact floor(val * 1e9 / div) by shift and subtract
   function automatic logic [63:0] scale_to_ns(logic [63:0] val, logic [63:0] div);
      logic [63:0] q, r;
      q = '0;
      r = '0;
      for (int b = ctuc_pkg::FRACTION_BITS - 1; b >= 0; b--) begin
         if (r >= div - r) begin
            r = r - (div - r);
            q = q * 2 + 1;
         end else begin
            r = r + r;
            q = q * 2;
         end
         if (ctuc_pkg::NS_PER_SEC[b]) begin
            if (r >= div - val) begin
               r = r - (div - val);
               q = q + 1;
            end else begin
               r = r + val;
            end
         end
      end
      return q;
   endfunction

   function automatic bit model_valid();
      logic [2:0] src, st;
      src = cfg_quality[5:3];
      st  = cfg_quality[2:0];
      if (cfg_revision == 0) return 0;
      if (src > 4 || st > 2) return 0;
      if (st == 0 && (src == 3 || src == 4)) return 0;
      if (cfg_mode == ctuc_pkg::MODE_PARTIAL) return 0;
      if (cfg_mode == ctuc_pkg::MODE_ANCHORED && cfg_rate == 0) return 0;
      if (cfg_uncertainty[63]) return 0;
      return 1;
   endfunction

   function automatic frame_result_type predict_utc(bit tp, logic [63:0] ticks, bit rp,
         logic [63:0] rate, logic signed [63:0] mono, logic [63:0] wall);
      frame_result_type res;
      logic [63:0] mag, secs, rem, whole, frac, delta, sum;
      bit neg;
      res.wall = wall;
      res.utc = '0;
      if (tp != rp || (rp && rate == 0)) res.status = ctuc_pkg::ST_BAD_RAW;
      else if (cfg_mode == ctuc_pkg::MODE_NONE) res.status = ctuc_pkg::ST_NO_MODEL;
      else if (!model_valid()) res.status = ctuc_pkg::ST_BAD_MODEL;
      else if (!tp || cfg_mode != ctuc_pkg::MODE_ANCHORED) res.status = ctuc_pkg::ST_MISSING;
      else if (rate != cfg_rate) res.status = ctuc_pkg::ST_RATE_MISMATCH;
      else if (mono < $signed(cfg_valid_from)) res.status = ctuc_pkg::ST_NOT_YET_VALID;
      else begin
         neg = ticks < cfg_anchor_ticks;
         mag = neg ? cfg_anchor_ticks - ticks : ticks - cfg_anchor_ticks;
         secs = mag / rate;
         rem = mag % rate;
         res.status = ctuc_pkg::ST_OVERFLOW;
         if (secs <= ctuc_pkg::SECS_MAX) begin
            frac = scale_to_ns(rem, rate);
            whole = secs * ctuc_pkg::NS_PER_SEC;
            if (frac <= ctuc_pkg::SMAX64 - whole) begin
               delta = whole + frac;
               if (neg) delta = 64'd0 - delta;
               sum = cfg_anchor_utc + delta;
               if (!(cfg_anchor_utc[63] == delta[63] && sum[63] != delta[63])) begin
                  res.status = ctuc_pkg::ST_CORRECTED;
                  res.utc = sum;
               end
            end
         end
      end
      return res;
   endfunction

   // result checker
   always @(posedge clock) begin
      frame_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status %0d", rsp_status);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_status !== exp_res.status || rsp_corrected_utc_ns !== exp_res.utc ||
                rsp_arrival_wall_ns !== exp_res.wall) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d utc %h wall %h, got st %0d utc %h wall %h",
                     exp_res.status, exp_res.utc, exp_res.wall, rsp_status,
                     rsp_corrected_utc_ns, rsp_arrival_wall_ns);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // csr writes end here, the next frame follows them
   task automatic send_frame(bit tp, logic [63:0] ticks, bit rp, logic [63:0] rate,
         logic [63:0] mono, logic [63:0] wall);
      csr_write_enable <= 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_ticks_present <= tp;
      req_frame_ticks <= ticks;
      req_rate_present <= rp;
      req_frame_rate_hz <= rate;
      req_received_mono_ns <= mono;
      req_received_wall_ns <= wall;
      do @(posedge clock); while (busy);
      pending_results.insert(pending_results.size(),
                             predict_utc(tp, ticks, rp, rate, mono, wall));
   endtask

   // wait until the pipeline is empty before touching registers
   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // enable stays high across back-to-back writes
   task automatic write_reg(logic [3:0] idx, logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         ctuc_pkg::REG_MODEL_MODE:   cfg_mode = ctuc_pkg::mode_type'(data[1:0]);
         ctuc_pkg::REG_ANCHOR_TICKS: cfg_anchor_ticks = data;
         ctuc_pkg::REG_ANCHOR_RATE:  cfg_rate = data;
         ctuc_pkg::REG_ANCHOR_UTC:   cfg_anchor_utc = data;
         ctuc_pkg::REG_VALID_FROM:   cfg_valid_from = data;
         ctuc_pkg::REG_REVISION:     cfg_revision = data[31:0];
         ctuc_pkg::REG_QUALITY:      cfg_quality = data[5:0];
         ctuc_pkg::REG_UNCERTAINTY:  cfg_uncertainty = data;
         default: ;
      endcase
   endtask

   task automatic good_model(logic [63:0] ticks, logic [63:0] rate, logic [63:0] utc,
         logic [63:0] from);
      write_reg(ctuc_pkg::REG_MODEL_MODE, 64'(ctuc_pkg::MODE_ANCHORED));
      write_reg(ctuc_pkg::REG_ANCHOR_TICKS, ticks);
      write_reg(ctuc_pkg::REG_ANCHOR_RATE, rate);
      write_reg(ctuc_pkg::REG_ANCHOR_UTC, utc);
      write_reg(ctuc_pkg::REG_VALID_FROM, from);
      write_reg(ctuc_pkg::REG_REVISION, 64'd1);
      write_reg(ctuc_pkg::REG_QUALITY, 64'd0);
      write_reg(ctuc_pkg::REG_UNCERTAINTY, 64'd0);
   endtask

   // frames against the reset model, and each status in turn
   task automatic test_status_checks();
      send_frame(1, 5, 1, 100, 0, 64'h1);
      send_frame(1, 5, 0, 100, 0, 64'h2);
      send_frame(0, 0, 1, 0, 0, 64'h3);
      drain();
      write_reg(ctuc_pkg::REG_MODEL_MODE, 64'(ctuc_pkg::MODE_NO_ANCHOR));
      send_frame(0, 0, 0, 0, 0, 64'h4);
      drain();
      write_reg(ctuc_pkg::REG_REVISION, 64'hFFFF_FFFF);
      write_reg(ctuc_pkg::REG_QUALITY, 64'({3'd3, 3'd0}));
      write_reg(ctuc_pkg::REG_UNCERTAINTY, 64'd5);
      send_frame(1, 7, 1, 9, 0, 64'h5);
      drain();
      write_reg(ctuc_pkg::REG_QUALITY, 64'({3'd1, 3'd2}));
      send_frame(1, 7, 1, 9, 0, 64'h6);
      drain();
      write_reg(ctuc_pkg::REG_MODEL_MODE, 64'(ctuc_pkg::MODE_PARTIAL));
      send_frame(1, 7, 1, 9, 0, 64'h7);
      drain();
      write_reg(ctuc_pkg::REG_MODEL_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
      write_reg(ctuc_pkg::REG_ANCHOR_RATE, 64'd0);
      send_frame(1, 7, 1, 9, 0, 64'h8);
      drain();
      good_model(1000, 1000, 0, 64'h8000_0000_0000_0000);
      write_reg(4'd9, rand64());
      write_reg(4'd15, rand64());
      send_frame(0, 0, 0, 0, 0, 64'h9);
      send_frame(1, 7, 1, 999, 0, 64'hA);
      send_frame(1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1000, 64'h7FFF_FFFF_FFFF_FFFF, 64'hB);
      send_frame(1, 0, 1, 1000, 0, 64'hC);
      drain();
      write_reg(ctuc_pkg::REG_VALID_FROM, 64'h7FFF_FFFF_FFFF_FFFF);
      send_frame(1, 5, 1, 1000, 64'h7FFF_FFFF_FFFF_FFFE, 64'hD);
      send_frame(1, 5, 1, 1000, 64'h7FFF_FFFF_FFFF_FFFF, 64'hE);
      drain();
   endtask

   // conversion near the signed limits
   task automatic test_extremes();
      good_model(0, 1, 64'h7FFF_FFFF_FFFF_FF00, 64'h8000_0000_0000_0000);
      send_frame(1, 0, 1, 1, 0, 64'h7FFF_FFFF_FFFF_FFFF);
      send_frame(1, 1, 1, 1, 0, 64'h8000_0000_0000_0000);
      send_frame(1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0, 0);
      drain();
      good_model(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
      send_frame(1, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1);
      send_frame(1, 64'hFFFF_FFFF_FFFF_FFFE, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 2);
      send_frame(1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 3);
      drain();
      good_model(64'h8000_0000, 3, 0, 64'h8000_0000_0000_0000);
      send_frame(1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 3, 0, 4);
      send_frame(1, 0, 1, 3, 0, 5);
      drain();
   endtask

   // random phases: mostly well-formed frames against a random good model
   task automatic test_random(int phases, int per_phase);
      logic [63:0] rate, anchor, from, ticks, mono;
      int kind;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 3))
            0: rate = 64'($urandom_range(1, 20));
            1: rate = 64'($urandom_range(1, 2_000_000_000));
            2: rate = rand64();
            default: rate = 64'd1 << $urandom_range(0, 63);
         endcase
         if (rate == 0) rate = 1;
         anchor = rand64();
         from = rand64();
         good_model(anchor, rate, ($urandom_range(0, 1) ? rand64() :
                    64'h7FFF_FFFF_0000_0000 ^ {32'd0, $urandom}), from);
         if ($urandom_range(0, 4) == 0)
            write_reg(ctuc_pkg::REG_QUALITY, 64'($urandom_range(0, 63)));
         if ($urandom_range(0, 6) == 0) write_reg(ctuc_pkg::REG_UNCERTAINTY, rand64());
         if ($urandom_range(0, 6) == 0)
            write_reg(ctuc_pkg::REG_MODEL_MODE, 64'($urandom_range(0, 3)));
         if ($urandom_range(0, 8) == 0)
            write_reg(ctuc_pkg::REG_REVISION, 64'($urandom_range(0, 1)));
         if (p == phases - 1) idle_on = 1'b0;
         for (int i = 0; i < per_phase; i++) begin
            kind = $urandom_range(0, 9);
            ticks = ($urandom_range(0, 1)) ? anchor + {{32{1'b0}}, $urandom} -
                    {{32{1'b0}}, $urandom} : rand64();
            mono = ($urandom_range(0, 7) == 0) ? rand64() :
                   from + {{33{1'b0}}, 31'($urandom_range(0, 32'h7FFF_FFFF))};
            if ($signed(mono) < $signed(from) && kind < 8) mono = from;
            if (kind < 8)
               send_frame(1, ticks, 1, rate, mono, rand64());
            else
               send_frame(1'($urandom_range(0, 1)), ticks, 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 1) ? rate :
                           ($urandom_range(0, 1) ? rand64() : 64'd0)),
                          mono, rand64());
         end
         drain();
      end
   endtask

   initial begin
      cfg_mode = ctuc_pkg::MODE_NONE;
      cfg_anchor_ticks = '0;
      cfg_rate = '0;
      cfg_anchor_utc = '0;
      cfg_valid_from = '0;
      cfg_revision = '0;
      cfg_quality = ctuc_pkg::QUALITY_RESET;
      cfg_uncertainty = ctuc_pkg::UNCERTAINTY_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_status_checks();
      test_extremes();
      test_random(8, 100);
      drain();
      repeat (ctuc_pkg::LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
